[rtl/core/assert_macros.svh]
// Assertion helper macros for the go-back-n sender RTL.
// Expects clk and rst_n in scope at the point of use.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, checked outside reset.
`define GBN_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) else $error(msg);

// Next-cycle implication, checked outside reset.
`define GBN_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) else $error(msg);

`endif

[rtl/core/gbn_pkg.sv]
// Shared types and constants of the go-back-n sender.
// No dependencies; used by gbn_alu and the go-back-n sender top level.
`timescale 1ns / 1ps

package gbn_pkg;

  localparam int SEQ_W  = 31;
  localparam int CSUM_W = 32;
  localparam int WORD_W = 32;
  localparam int ALU_W  = 33;
  localparam int TMR_W  = 16;
  localparam int CMD_W  = 2;
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 31;

  localparam logic [CMD_W-1:0] CMD_MSG  = 2'd0;
  localparam logic [CMD_W-1:0] CMD_PKT  = 2'd1;
  localparam logic [CMD_W-1:0] CMD_TICK = 2'd2;

  localparam logic [CFG_IDX_W-1:0] CFG_ACK_MARKER = 1'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT    = 1'd1;

  localparam logic [SEQ_W-1:0] ACK_MARKER_RST = 31'd1;
  localparam logic [TMR_W-1:0] TIMEOUT_RST    = 16'd20;

  // Request to the shared adder: sum = a + b + cin, eq = (sum[31:0] == cmp)
  typedef struct packed {
    logic [ALU_W-1:0]  a;
    logic [ALU_W-1:0]  b;
    logic              cin;
    logic [WORD_W-1:0] cmp;
  } alu_req_t;

endpackage

[rtl/core/gbn_alu.sv]
// Shared 33-bit adder with equality compare for the sender sequencer.
// Depends on gbn_pkg (alu_req_t).
`timescale 1ns / 1ps

module gbn_alu (
  input  gbn_pkg::alu_req_t        req,
  output logic [gbn_pkg::ALU_W-1:0] sum,
  output logic                      eq
);
  import gbn_pkg::*;

  assign sum = req.a + req.b + {{(ALU_W-1){1'b0}}, req.cin};
  assign eq  = (sum[WORD_W-1:0] == req.cmp);

endmodule

[rtl/core/gbn_ram.sv]
// Simple dual-port RAM, one write and one registered read port.
// No package dependencies; holds the window and pending rings.
`timescale 1ns / 1ps

module gbn_ram #(
  parameter int DEPTH = 8,
  parameter int WIDTH = 8,
  parameter int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

[rtl/core/go_back_n_sender.sv]
// Go-back-n sender top level: sequencer, window/pending rings, output register.
// Depends on gbn_pkg, gbn_alu, gbn_ram and assert_macros.svh.
//
//  channel | dir | handshake          | payload
//  in_     | in  | in_tvalid/tready   | tuser: command; tdata: handle, sums, pkt fields
//  out_    | out | out_tvalid/tready  | tdata: seq, handle, checksum; tuser: resend; tlast
//  cfg_    | in  | cfg_valid/ready    | cfg_index, cfg_data
//
// States per request: a message goes IDLE, MSG, then SEND if the window has room;
// a tick goes IDLE, TICK, then RESEND once per resent packet; an ack goes IDLE,
// CHK1, CHK2 and, if accepted, FREE once per entry compared (each freed entry, plus
// the one that ends the walk unless the window empties), POST, DRAIN, then SEND and
// DRAIN per queued message moved into the window. The shared adder and the one read
// port of each ring set this sequencing. Output backpressure holds SEND and RESEND.
// Reset is synchronous; the rings are not cleared (counts track live entries).
`timescale 1ns / 1ps
`include "assert_macros.svh"

module go_back_n_sender #(
  parameter int WINDOW        = 8,
  parameter int PENDING_DEPTH = 32,
  parameter int HANDLE_BITS   = 8,
  parameter int PAYLOAD_BYTES = 20,
  // derived
  parameter int SUM_W  = $clog2(PAYLOAD_BYTES * 128 + 1) + 1,
  parameter int IN_W   = ((HANDLE_BITS + 2 * SUM_W + 96) + 7) / 8 * 8,
  parameter int OUT_W  = ((31 + HANDLE_BITS + 32) + 7) / 8 * 8
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           in_tvalid,
  output logic                           in_tready,
  // msg_handle, msg_payload_sum, pkt_seq, pkt_acknum, pkt_checksum, pkt_payload_sum
  input  logic [IN_W-1:0]                in_tdata,
  // command
  input  logic [gbn_pkg::CMD_W-1:0]      in_tuser,
  output logic                           out_tvalid,
  input  logic                           out_tready,
  // out_seq, out_handle, out_checksum
  output logic [OUT_W-1:0]               out_tdata,
  // is_resend
  output logic                           out_tuser,
  output logic                           out_tlast,
  input  logic                           cfg_valid,
  output logic                           cfg_ready,
  input  logic [gbn_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [gbn_pkg::CFG_DATA_W-1:0] cfg_data
);
  import gbn_pkg::*;

  localparam int HB    = HANDLE_BITS;
  localparam int WA    = (WINDOW > 1) ? $clog2(WINDOW) : 1;
  localparam int WC_W  = $clog2(WINDOW + 1);
  localparam int PA    = (PENDING_DEPTH > 1) ? $clog2(PENDING_DEPTH) : 1;
  localparam int PC_W  = $clog2(PENDING_DEPTH + 1);
  localparam int WE_W  = SEQ_W + HB + CSUM_W;
  localparam int PE_W  = HB + SUM_W;

  // input field offsets
  localparam int O_HDL  = 0;
  localparam int O_MSUM = O_HDL + HB;
  localparam int O_SEQ  = O_MSUM + SUM_W;
  localparam int O_ACK  = O_SEQ + WORD_W;
  localparam int O_CSUM = O_ACK + WORD_W;
  localparam int O_PSUM = O_CSUM + WORD_W;

  localparam logic [3:0] S_IDLE   = 4'd0;
  localparam logic [3:0] S_MSG    = 4'd1;
  localparam logic [3:0] S_CHK1   = 4'd2;
  localparam logic [3:0] S_CHK2   = 4'd3;
  localparam logic [3:0] S_FREE   = 4'd4;
  localparam logic [3:0] S_POST   = 4'd5;
  localparam logic [3:0] S_DRAIN  = 4'd6;
  localparam logic [3:0] S_SEND   = 4'd7;
  localparam logic [3:0] S_TICK   = 4'd8;
  localparam logic [3:0] S_RESEND = 4'd9;

  logic [3:0] state_r, state_nxt;

  // latched request payload
  logic [HB-1:0]     hdl_r;
  logic [SUM_W-1:0]  msum_r;
  logic [WORD_W-1:0] pseq_r, ackn_r, pcsum_r;
  logic [SUM_W-1:0]  psum_r;
  logic [WORD_W-1:0] t_r, t_nxt;

  logic [WA-1:0]   win_head_r, win_head_nxt;
  logic [WC_W-1:0] win_count_r, win_count_nxt;
  logic [WA-1:0]   win_ptr_r, win_ptr_nxt;
  logic [WC_W-1:0] res_idx_r, res_idx_nxt;
  logic [PA-1:0]   pend_head_r, pend_head_nxt;
  logic [PC_W-1:0] pend_count_r, pend_count_nxt;
  logic [SEQ_W-1:0] next_seq_r, next_seq_nxt;
  logic             tmr_run_r, tmr_run_nxt;
  logic [TMR_W-1:0] tmr_left_r, tmr_left_nxt;
  logic             from_pend_r, from_pend_nxt;
  logic [SEQ_W-1:0] ack_marker_r;
  logic [TMR_W-1:0] timeout_r;

  logic              out_valid_r, out_valid_nxt;
  logic [SEQ_W-1:0]  out_seq_r, out_seq_nxt;
  logic [HB-1:0]     out_hdl_r, out_hdl_nxt;
  logic [CSUM_W-1:0] out_csum_r, out_csum_nxt;
  logic              out_resend_r, out_resend_nxt;
  logic              out_last_r, out_last_nxt;

  // ring ports
  logic            win_we, win_re;
  logic [WA-1:0]   win_waddr, win_raddr;
  logic [WE_W-1:0] win_wdata, win_rdata;
  logic            pend_we, pend_re;
  logic [PA-1:0]   pend_waddr, pend_raddr;
  logic [PE_W-1:0] pend_wdata, pend_rdata;

  alu_req_t         alu_req;
  logic [ALU_W-1:0] alu_sum;
  logic             alu_eq;

  logic [WA-1:0]    win_head_inc, win_ptr_inc, win_tail;
  logic [WC_W:0]    win_tail_ext;
  logic [PA-1:0]    pend_head_inc, pend_tail;
  logic [PC_W:0]    pend_tail_ext;
  logic             out_free, in_fire;
  logic [HB-1:0]    send_hdl;
  logic [SUM_W-1:0] send_sum;
  logic [SEQ_W-1:0] rd_seq;
  logic [HB-1:0]    rd_hdl;
  logic [CSUM_W-1:0] rd_csum;

  gbn_alu u_alu (
    .req (alu_req),
    .sum (alu_sum),
    .eq  (alu_eq)
  );

  gbn_ram #(.DEPTH(WINDOW), .WIDTH(WE_W), .AW(WA)) u_win_ram (
    .clk   (clk),
    .we    (win_we),
    .waddr (win_waddr),
    .wdata (win_wdata),
    .re    (win_re),
    .raddr (win_raddr),
    .rdata (win_rdata)
  );

  gbn_ram #(.DEPTH(PENDING_DEPTH), .WIDTH(PE_W), .AW(PA)) u_pend_ram (
    .clk   (clk),
    .we    (pend_we),
    .waddr (pend_waddr),
    .wdata (pend_wdata),
    .re    (pend_re),
    .raddr (pend_raddr),
    .rdata (pend_rdata)
  );

  assign in_tready  = (state_r == S_IDLE);
  assign in_fire    = in_tvalid && in_tready;
  assign cfg_ready  = 1'b1;
  assign out_tvalid = out_valid_r;
  assign out_tdata  = OUT_W'({out_csum_r, out_hdl_r, out_seq_r});
  assign out_tuser  = out_resend_r;
  assign out_tlast  = out_last_r;
  assign out_free   = !out_valid_r || out_tready;

  // ring pointer arithmetic (depths need not be powers of two)
  assign win_head_inc  = (win_head_r == WA'(WINDOW - 1)) ? '0 : win_head_r + 1'b1;
  assign win_ptr_inc   = (win_ptr_r == WA'(WINDOW - 1)) ? '0 : win_ptr_r + 1'b1;
  assign win_tail_ext  = {{(WC_W + 1 - WA){1'b0}}, win_head_r} + {1'b0, win_count_r};
  assign win_tail      = (win_tail_ext >= (WC_W + 1)'(WINDOW))
                         ? WA'(win_tail_ext - (WC_W + 1)'(WINDOW)) : WA'(win_tail_ext);
  assign pend_head_inc = (pend_head_r == PA'(PENDING_DEPTH - 1)) ? '0 : pend_head_r + 1'b1;
  assign pend_tail_ext = {{(PC_W + 1 - PA){1'b0}}, pend_head_r} + {1'b0, pend_count_r};
  assign pend_tail     = (pend_tail_ext >= (PC_W + 1)'(PENDING_DEPTH))
                         ? PA'(pend_tail_ext - (PC_W + 1)'(PENDING_DEPTH))
                         : PA'(pend_tail_ext);

  assign rd_seq  = win_rdata[SEQ_W-1:0];
  assign rd_hdl  = win_rdata[SEQ_W +: HB];
  assign rd_csum = win_rdata[SEQ_W + HB +: CSUM_W];

  assign send_hdl = from_pend_r ? pend_rdata[HB-1:0] : hdl_r;
  assign send_sum = from_pend_r ? pend_rdata[HB +: SUM_W] : msum_r;

  always_comb begin
    state_nxt      = state_r;
    t_nxt          = t_r;
    win_head_nxt   = win_head_r;
    win_count_nxt  = win_count_r;
    win_ptr_nxt    = win_ptr_r;
    res_idx_nxt    = res_idx_r;
    pend_head_nxt  = pend_head_r;
    pend_count_nxt = pend_count_r;
    next_seq_nxt   = next_seq_r;
    tmr_run_nxt    = tmr_run_r;
    tmr_left_nxt   = tmr_left_r;
    from_pend_nxt  = from_pend_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_seq_nxt    = out_seq_r;
    out_hdl_nxt    = out_hdl_r;
    out_csum_nxt   = out_csum_r;
    out_resend_nxt = out_resend_r;
    out_last_nxt   = out_last_r;

    win_we     = 1'b0;
    win_waddr  = win_tail;
    win_wdata  = {alu_sum[CSUM_W-1:0], send_hdl, next_seq_r};
    win_re     = 1'b0;
    win_raddr  = win_head_r;
    pend_we    = 1'b0;
    pend_waddr = pend_tail;
    pend_wdata = {msum_r, hdl_r};
    pend_re    = 1'b0;
    pend_raddr = pend_head_r;

    alu_req = '0;

    unique case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          unique case (in_tuser)
            CMD_MSG:  state_nxt = S_MSG;
            CMD_PKT:  state_nxt = S_CHK1;
            CMD_TICK: state_nxt = S_TICK;
            default:  state_nxt = S_IDLE;
          endcase
        end
      end

      S_MSG: begin
        state_nxt = S_IDLE;
        if (win_count_r < WC_W'(WINDOW)) begin
          from_pend_nxt = 1'b0;
          state_nxt     = S_SEND;
        end else if (pend_count_r < PC_W'(PENDING_DEPTH)) begin
          pend_we        = 1'b1;
          pend_count_nxt = pend_count_r + 1'b1;
        end
      end

      // checksum check: seq + acknum, then + payload sum against checksum
      S_CHK1: begin
        alu_req.a = {pseq_r[WORD_W-1], pseq_r};
        alu_req.b = {ackn_r[WORD_W-1], ackn_r};
        t_nxt     = alu_sum[WORD_W-1:0];
        state_nxt = S_CHK2;
      end

      S_CHK2: begin
        alu_req.a   = {t_r[WORD_W-1], t_r};
        alu_req.b   = {{(ALU_W - SUM_W){psum_r[SUM_W-1]}}, psum_r};
        alu_req.cmp = pcsum_r;
        state_nxt   = S_IDLE;
        if (alu_eq && ackn_r == {1'b0, ack_marker_r} && win_count_r != '0) begin
          win_re      = 1'b1;
          win_raddr   = win_head_r;
          win_ptr_nxt = win_head_r;
          state_nxt   = S_FREE;
        end
      end

      // signed acked seq minus entry seq; non-negative frees the entry
      S_FREE: begin
        alu_req.a   = {pseq_r[WORD_W-1], pseq_r};
        alu_req.b   = ~{2'b00, rd_seq};
        alu_req.cin = 1'b1;
        state_nxt   = S_POST;
        if (!alu_sum[ALU_W-1]) begin
          win_head_nxt  = win_head_inc;
          win_count_nxt = win_count_r - 1'b1;
          if (win_count_r > WC_W'(1)) begin
            win_re      = 1'b1;
            win_raddr   = win_ptr_inc;
            win_ptr_nxt = win_ptr_inc;
            state_nxt   = S_FREE;
          end
        end
      end

      S_POST: begin
        if (win_count_r == '0) begin
          tmr_run_nxt  = 1'b0;
          tmr_left_nxt = '0;
        end
        state_nxt = S_DRAIN;
      end

      S_DRAIN: begin
        state_nxt = S_IDLE;
        if (win_count_r < WC_W'(WINDOW) && pend_count_r != '0) begin
          pend_re        = 1'b1;
          pend_head_nxt  = pend_head_inc;
          pend_count_nxt = pend_count_r - 1'b1;
          from_pend_nxt  = 1'b1;
          state_nxt      = S_SEND;
        end
      end

      S_SEND: begin
        alu_req.a = {2'b00, next_seq_r};
        alu_req.b = {{(ALU_W - SUM_W){send_sum[SUM_W-1]}}, send_sum};
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_seq_nxt    = next_seq_r;
          out_hdl_nxt    = send_hdl;
          out_csum_nxt   = alu_sum[CSUM_W-1:0];
          out_resend_nxt = 1'b0;
          out_last_nxt   = from_pend_r
                           ? !(win_count_r < WC_W'(WINDOW - 1) && pend_count_r != '0)
                           : 1'b1;
          win_we        = 1'b1;
          win_count_nxt = win_count_r + 1'b1;
          next_seq_nxt  = next_seq_r + 1'b1;
          if (win_count_r == '0 && !tmr_run_r) begin
            tmr_run_nxt  = 1'b1;
            tmr_left_nxt = timeout_r;
          end
          state_nxt = from_pend_r ? S_DRAIN : S_IDLE;
        end
      end

      S_TICK: begin
        state_nxt = S_IDLE;
        if (tmr_run_r) begin
          if (tmr_left_r <= TMR_W'(1)) begin
            if (win_count_r != '0) begin
              tmr_left_nxt = timeout_r;
              win_re       = 1'b1;
              win_raddr    = win_head_r;
              win_ptr_nxt  = win_head_r;
              res_idx_nxt  = '0;
              state_nxt    = S_RESEND;
            end else begin
              tmr_run_nxt  = 1'b0;
              tmr_left_nxt = '0;
            end
          end else begin
            tmr_left_nxt = tmr_left_r - 1'b1;
          end
        end
      end

      S_RESEND: begin
        if (out_free) begin
          out_valid_nxt  = 1'b1;
          out_seq_nxt    = rd_seq;
          out_hdl_nxt    = rd_hdl;
          out_csum_nxt   = rd_csum;
          out_resend_nxt = 1'b1;
          out_last_nxt   = (res_idx_r + 1'b1 == win_count_r);
          res_idx_nxt    = res_idx_r + 1'b1;
          if (res_idx_r + 1'b1 == win_count_r) begin
            state_nxt = S_IDLE;
          end else begin
            win_re      = 1'b1;
            win_raddr   = win_ptr_inc;
            win_ptr_nxt = win_ptr_inc;
          end
        end
      end

      default: state_nxt = S_IDLE;
    endcase
  end

  // request payload capture, plus the datapath registers without reset
  always_ff @(posedge clk) begin
    if (in_fire) begin
      hdl_r   <= in_tdata[O_HDL +: HB];
      msum_r  <= in_tdata[O_MSUM +: SUM_W];
      pseq_r  <= in_tdata[O_SEQ +: WORD_W];
      ackn_r  <= in_tdata[O_ACK +: WORD_W];
      pcsum_r <= in_tdata[O_CSUM +: WORD_W];
      psum_r  <= in_tdata[O_PSUM +: SUM_W];
    end
    t_r          <= t_nxt;
    win_ptr_r    <= win_ptr_nxt;
    res_idx_r    <= res_idx_nxt;
    from_pend_r  <= from_pend_nxt;
    out_seq_r    <= out_seq_nxt;
    out_hdl_r    <= out_hdl_nxt;
    out_csum_r   <= out_csum_nxt;
    out_resend_r <= out_resend_nxt;
    out_last_r   <= out_last_nxt;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      win_head_r   <= '0;
      win_count_r  <= '0;
      pend_head_r  <= '0;
      pend_count_r <= '0;
      next_seq_r   <= '0;
      tmr_run_r    <= 1'b0;
      tmr_left_r   <= '0;
      out_valid_r  <= 1'b0;
      ack_marker_r <= ACK_MARKER_RST;
      timeout_r    <= TIMEOUT_RST;
    end else begin
      state_r      <= state_nxt;
      win_head_r   <= win_head_nxt;
      win_count_r  <= win_count_nxt;
      pend_head_r  <= pend_head_nxt;
      pend_count_r <= pend_count_nxt;
      next_seq_r   <= next_seq_nxt;
      tmr_run_r    <= tmr_run_nxt;
      tmr_left_r   <= tmr_left_nxt;
      out_valid_r  <= out_valid_nxt;
      if (cfg_valid && cfg_ready) begin
        unique case (cfg_index)
          CFG_ACK_MARKER: ack_marker_r <= cfg_data[SEQ_W-1:0];
          CFG_TIMEOUT:    timeout_r    <= cfg_data[TMR_W-1:0];
          default: ;
        endcase
      end
    end
  end

  `GBN_ASSERT_IMP(a_win_bound, 1'b1, win_count_r <= WC_W'(WINDOW), "window count overflow")
  `GBN_ASSERT_IMP(a_pend_bound, 1'b1, pend_count_r <= PC_W'(PENDING_DEPTH), "pending overflow")
  `GBN_ASSERT_IMP(a_tmr_win, state_r == S_IDLE, tmr_run_r == (win_count_r != '0), "timer/window mismatch")
  `GBN_ASSERT_NXT(a_out_load, out_valid_r && !out_tready, out_valid_r, "result dropped")

endmodule
